[rtl/tks_pkg.sv]
package tks_pkg;

    localparam int CLASS_COUNT = 1000;
    localparam int TOP_COUNT   = 5;

    localparam int SCORE_W = 24;
    localparam int MAG_W   = SCORE_W - 1;
    localparam int IDX_W   = 10;
    localparam int RANK_W  = 3;
    localparam int PCT_W   = 30;
    localparam int CNT_W   = $clog2(CLASS_COUNT + 1);

    localparam logic [IDX_W-1:0]  LABEL_RESET = IDX_W'(1000);
    localparam logic [6:0]        PCT_SCALE   = 7'd100;
    localparam logic [RANK_W-1:0] LAST_RANK   = RANK_W'(TOP_COUNT - 1);

    // frame result store: two rows, one per finished frame
    localparam int FRAME_SLOTS = 2;
    localparam int PTR_W       = $clog2(FRAME_SLOTS);
    localparam int SLOT_CNT_W  = $clog2(FRAME_SLOTS + 1);

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      final_item;
    } t_req;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [IDX_W-1:0]  class_index;
        logic [PCT_W-1:0]  percent;
        logic              entry_valid;
        logic              last_of_run;
    } t_res;

    // one finished frame: the ranked list as it stood after its last score
    typedef struct packed {
        logic [TOP_COUNT-1:0]            filled;
        logic [TOP_COUNT-1:0][IDX_W-1:0] index;
        logic [TOP_COUNT-1:0][MAG_W-1:0] score;
    } t_row;

    typedef struct packed {
        logic accept;
        logic final_item;
    } t_list_ctl;

endpackage

[rtl/top_k_score_select.sv]
// channel   | direction | valid        | ready        | payload
// ----------+-----------+--------------+--------------+--------------------------
// request   | in        | i_req_valid  | o_req_ready  | i_req (tks_pkg::t_req)
// result    | out       | o_res_valid  | i_res_ready  | o_res (tks_pkg::t_res)
// config    | in        | i_cfg_we     | (none)       | i_cfg_data (label count)
//
// one score request per cycle while o_req_ready is high; each request does one compare-and-shift of the five slot list
// a final request writes its frame row to a two-row store; five results follow, one a cycle while i_res_ready is high
// result path: row read register, rank select and score*100, output register
// frames shorter than five requests back up once both rows are occupied (o_req_ready low)
// synchronous active-low reset clears the list, the row counts and the output valid
// a stalled result holds in the output register while requests keep flowing

module top_k_score_select (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  tks_pkg::t_req               i_req,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output tks_pkg::t_res               o_res,
    input  logic                        i_cfg_we,
    input  logic [tks_pkg::IDX_W-1:0]   i_cfg_data
);

    // configuration
    logic [tks_pkg::IDX_W-1:0] r_label;

    // request side
    logic               req_acc;
    logic               row_we;
    tks_pkg::t_list_ctl list_ctl;
    tks_pkg::t_row      wr_row;

    // frame row store and its bookkeeping
    tks_pkg::t_row                  r_mem [tks_pkg::FRAME_SLOTS];
    tks_pkg::t_row                  r_rd_data;
    logic [tks_pkg::PTR_W-1:0]      r_wp, r_rp;
    logic [tks_pkg::SLOT_CNT_W-1:0] r_slots;
    logic                           rd_en;

    // drain sequencer
    logic                         r_row_vld;
    logic [tks_pkg::RANK_W-1:0]   r_rank;
    logic                         r_run_ok;
    logic                         out_load;
    logic                         row_done;

    // result formation
    logic                         sel_filled;
    logic [tks_pkg::IDX_W-1:0]    sel_index;
    logic [tks_pkg::MAG_W-1:0]    sel_score;
    logic                         sel_ok;
    logic [tks_pkg::PCT_W-1:0]    pct_mul;
    tks_pkg::t_res                n_res;
    tks_pkg::t_res                r_res;
    logic                         r_res_vld;

    // requests are taken while a row is free for the frame end
    assign o_req_ready = (r_slots != tks_pkg::SLOT_CNT_W'(tks_pkg::FRAME_SLOTS));
    assign req_acc     = i_req_valid && o_req_ready;
    assign row_we      = req_acc && i_req.final_item;

    assign list_ctl.accept     = req_acc;
    assign list_ctl.final_item = i_req.final_item;

    tks_list u_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (list_ctl),
        .i_score (i_req.score),
        .o_row   (wr_row)
    );

    // a row is read only once r_slots shows it committed, and a write while
    // one row is held goes to the other one, so read and write never collide
    assign out_load = r_row_vld && (!r_res_vld || i_res_ready);
    assign row_done = out_load && (r_rank == tks_pkg::LAST_RANK);
    // prefetch the next frame's row while the last rank of this one goes out
    assign rd_en    = (r_slots != '0) && (!r_row_vld || row_done);

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_mem[r_wp] <= wr_row;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_label <= tks_pkg::LABEL_RESET;
        end else if (i_cfg_we) begin
            r_label <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_slots <= '0;
        end else begin
            if (row_we) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            // a row is released as soon as it sits in the read register
            r_slots <= r_slots + tks_pkg::SLOT_CNT_W'(row_we) - tks_pkg::SLOT_CNT_W'(rd_en);
        end
    end

    // rank select out of the held row
    assign sel_filled = r_rd_data.filled[r_rank];
    assign sel_index  = r_rd_data.index[r_rank];
    assign sel_score  = r_rd_data.score[r_rank];
    // first empty slot or first index past the labels ends the run
    assign sel_ok     = r_run_ok && sel_filled && (sel_index < r_label);
    assign pct_mul    = tks_pkg::PCT_W'(sel_score) * tks_pkg::PCT_W'(tks_pkg::PCT_SCALE);

    always_comb begin
        n_res.rank        = r_rank;
        n_res.class_index = sel_ok ? sel_index : '0;
        n_res.percent     = sel_ok ? pct_mul : '0;
        n_res.entry_valid = sel_ok;
        n_res.last_of_run = (r_rank == tks_pkg::LAST_RANK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= 1'b0;
            r_rank    <= '0;
            r_run_ok  <= 1'b1;
        end else begin
            r_row_vld <= rd_en || (r_row_vld && !row_done);
            if (row_done) begin
                r_rank   <= '0;
                r_run_ok <= 1'b1;
            end else if (out_load) begin
                r_rank   <= r_rank + 1'b1;
                r_run_ok <= sel_ok;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (out_load) begin
            r_res_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule

[rtl/tks_list.sv]
module tks_list (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  tks_pkg::t_list_ctl                 i_ctl,
    input  logic signed [tks_pkg::SCORE_W-1:0] i_score,
    output tks_pkg::t_row                      o_row
);

    logic [tks_pkg::TOP_COUNT-1:0]                     r_filled, n_filled;
    logic [tks_pkg::TOP_COUNT-1:0][tks_pkg::IDX_W-1:0] r_index, n_index;
    logic [tks_pkg::TOP_COUNT-1:0][tks_pkg::MAG_W-1:0] r_score, n_score;
    logic [tks_pkg::CNT_W-1:0]                         r_cnt, n_cnt;

    logic [tks_pkg::TOP_COUNT-1:0]                     take;
    logic [tks_pkg::TOP_COUNT-1:0]                     prev_take;
    logic [tks_pkg::TOP_COUNT-1:0][tks_pkg::IDX_W-1:0] sh_index;
    logic [tks_pkg::TOP_COUNT-1:0][tks_pkg::MAG_W-1:0] sh_score;
    logic [tks_pkg::TOP_COUNT-1:0]                     sh_filled;
    logic [tks_pkg::TOP_COUNT-1:0]                     ins_filled;
    logic [tks_pkg::TOP_COUNT-1:0][tks_pkg::IDX_W-1:0] ins_index;
    logic [tks_pkg::TOP_COUNT-1:0][tks_pkg::MAG_W-1:0] ins_score;
    logic [tks_pkg::MAG_W-1:0]                         mag;
    logic [tks_pkg::IDX_W-1:0]                         cur_idx;
    logic                                              counting;
    logic                                              do_ins;

    assign mag      = i_score[tks_pkg::MAG_W-1:0];
    assign cur_idx  = tks_pkg::IDX_W'(r_cnt);
    assign counting = i_ctl.accept && (r_cnt < tks_pkg::CNT_W'(tks_pkg::CLASS_COUNT));
    // strictly positive: sign clear and not zero
    assign do_ins   = counting && !i_score[tks_pkg::SCORE_W-1] && (mag != '0);

    // one compare per slot; list is sorted so take is a thermometer
    always_comb begin
        for (int k = 0; k < tks_pkg::TOP_COUNT; k++) begin
            take[k] = !r_filled[k] || (mag > r_score[k]);
        end
        prev_take    = take << 1;
        sh_score[0]  = mag;
        sh_index[0]  = cur_idx;
        sh_filled[0] = 1'b1;
        for (int k = 1; k < tks_pkg::TOP_COUNT; k++) begin
            sh_score[k]  = r_score[k-1];
            sh_index[k]  = r_index[k-1];
            sh_filled[k] = r_filled[k-1];
        end
        for (int k = 0; k < tks_pkg::TOP_COUNT; k++) begin
            if (do_ins && take[k] && prev_take[k]) begin
                ins_score[k]  = sh_score[k];
                ins_index[k]  = sh_index[k];
                ins_filled[k] = sh_filled[k];
            end else if (do_ins && take[k]) begin
                ins_score[k]  = mag;
                ins_index[k]  = cur_idx;
                ins_filled[k] = 1'b1;
            end else begin
                ins_score[k]  = r_score[k];
                ins_index[k]  = r_index[k];
                ins_filled[k] = r_filled[k];
            end
        end
    end

    always_comb begin
        n_score  = ins_score;
        n_index  = ins_index;
        n_filled = ins_filled;
        n_cnt    = counting ? r_cnt + 1'b1 : r_cnt;
        if (i_ctl.accept && i_ctl.final_item) begin
            n_score  = '0;
            n_index  = '0;
            n_filled = '0;
            n_cnt    = '0;
        end
    end

    // the frame's list including its final score, for the row write
    assign o_row.filled = ins_filled;
    assign o_row.index  = ins_index;
    assign o_row.score  = ins_score;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score  <= '0;
            r_index  <= '0;
            r_filled <= '0;
            r_cnt    <= '0;
        end else begin
            r_score  <= n_score;
            r_index  <= n_index;
            r_filled <= n_filled;
            r_cnt    <= n_cnt;
        end
    end

endmodule

[rtl/tks_checker.sv]
module tks_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_res_valid,
    input logic                      i_res_ready,
    input tks_pkg::t_res             o_res
);

    // reset empties the output side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

    // only the last rank closes a frame
    a_last_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.last_of_run == (o_res.rank == tks_pkg::LAST_RANK)))
        else $error("last_of_run does not match rank");

    // an invalid rank carries no class and no score
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.entry_valid |-> (o_res.class_index == '0) && (o_res.percent == '0))
        else $error("invalid rank with payload");

    // ranks go out in order within a frame
    a_rank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_ready && !o_res.last_of_run ##1 o_res_valid
            |-> (o_res.rank == $past(o_res.rank) + 1'b1) || !$past(i_res_ready)
                || (o_res.rank == $past(o_res.rank)))
        else $error("rank out of order");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("stalled result changed");

endmodule

bind top_k_score_select tks_checker u_tks_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);

[bench/top_k_score_select_test.sv]
`timescale 1ns / 1ps

module top_k_score_select_test;
    import tks_pkg::*;

    // clock period halves, cycles, limits
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PERCENT_SCALE  = 100;
    localparam int PHASE_ITEMS    = 40;
    localparam int PHASE_COUNT    = 6;

    // receiver stall patterns
    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PATTERN,
        STALL_LONG
    } t_stall_mode;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_req_valid = 1'b0;
    logic          o_req_ready;
    t_req          i_req       = '0;
    logic          o_res_valid;
    logic          i_res_ready = 1'b0;
    t_res          o_res;
    logic          i_cfg_we    = 1'b0;
    logic [IDX_W-1:0] i_cfg_data = '0;

    top_k_score_select dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // ranking predictor: its own copy of the list, counter and label count
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] ranked_score [TOP_COUNT];
    logic [IDX_W-1:0] ranked_index [TOP_COUNT];
    logic             ranked_filled[TOP_COUNT];
    int               frame_position = 0;
    logic [IDX_W-1:0] label_limit    = LABEL_RESET;

    // ranked results waiting to come out of the block, oldest first
    t_res expected_ranks[$];

    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    t_stall_mode stall_mode     = STALL_NONE;
    int          stall_phase    = 0;
    int          stall_left     = 0;
    int          burst_gap_max  = 0;
    int          burst_left     = 0;

    task automatic clear_ranking();
        for (int k = 0; k < TOP_COUNT; k++) begin
            ranked_score[k]  = '0;
            ranked_index[k]  = '0;
            ranked_filled[k] = 1'b0;
        end
        frame_position = 0;
    endtask

    // fold one accepted score request into the list; on a final request
    // queue the five ranked results and start a new frame
    task automatic rank_score(input t_req req);
        int               pos;
        logic [MAG_W-1:0] mag;
        logic             run_ok;
        t_res             res;
        if (frame_position < CLASS_COUNT) begin
            // zero and negative scores never enter the list
            if (req.score > 0) begin
                mag = req.score[MAG_W-1:0];
                pos = TOP_COUNT;
                // strict compare: an equal score stays behind the earlier class
                for (int k = 0; k < TOP_COUNT; k++)
                    if (pos == TOP_COUNT && (!ranked_filled[k] || mag > ranked_score[k]))
                        pos = k;
                if (pos < TOP_COUNT) begin
                    for (int k = TOP_COUNT - 1; k > pos; k--) begin
                        ranked_score[k]  = ranked_score[k-1];
                        ranked_index[k]  = ranked_index[k-1];
                        ranked_filled[k] = ranked_filled[k-1];
                    end
                    ranked_score[pos]  = mag;
                    ranked_index[pos]  = IDX_W'(frame_position);
                    ranked_filled[pos] = 1'b1;
                end
            end
            frame_position++;
        end
        if (req.final_item) begin
            run_ok = 1'b1;
            for (int k = 0; k < TOP_COUNT; k++) begin
                // an empty slot or one past the label count ends the report
                run_ok = run_ok && ranked_filled[k] && (ranked_index[k] < label_limit);
                res.rank        = RANK_W'(k);
                res.class_index = run_ok ? ranked_index[k] : '0;
                res.percent     = run_ok ? PCT_W'(ranked_score[k]) * PCT_W'(PERCENT_SCALE)
                                         : '0;
                res.entry_valid = run_ok;
                res.last_of_run = (k == TOP_COUNT - 1);
                expected_ranks.push_back(res);
            end
            clear_ranking();
        end
    endtask

    // ------------------------------------------------------------------
    // request side: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    task automatic send_score(input logic signed [SCORE_W-1:0] s, input logic fin);
        t_req req;
        int   gap;
        req.score      = s;
        req.final_item = fin;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = (burst_gap_max > 0) ? $urandom_range(0, burst_gap_max) : 0;
            if (gap > 0) begin
                i_req_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        // valid stays high into the next request when there is no gap
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (!o_req_ready);
        rank_score(req);
    endtask

    // hold off requests until every ranked result is out, then let the
    // result pipe settle
    task automatic drain_results();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
        burst_left = 0;
        while (expected_ranks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // label count only changes while the block is idle
    task automatic write_label_count(input logic [IDX_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        label_limit = value;
    endtask

    // mix of tiny positives (ties), full random, negatives, zero and near-max
    function automatic logic signed [SCORE_W-1:0] pick_score();
        int                        sel;
        logic signed [SCORE_W-1:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            v = SCORE_W'($urandom_range(1, 64));
        else if (sel < 55)
            v = SCORE_W'($urandom);
        else if (sel < 70) begin
            v = SCORE_W'($urandom_range(1, 8388608));
            v = -v;
        end else if (sel < 80)
            v = '0;
        else if (sel < 90)
            v = SCORE_W'($urandom_range(8388000, 8388607));
        else
            v = SCORE_W'($urandom_range(1, 8388607));
        return v;
    endfunction

    // mostly short frames, some medium, a few long
    function automatic int pick_frame_length();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70)
            return $urandom_range(1, 8);
        else if (sel < 95)
            return $urandom_range(9, 20);
        return $urandom_range(21, 60);
    endfunction

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++)
            send_score(pick_score(), i == len - 1);
    endtask

    // ------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------

    // reset label count, score extremes, ties going to the lower class
    task automatic test_score_extremes();
        send_score(24'sd8388607, 1'b0);
        send_score(-24'sd8388608, 1'b0);
        send_score(24'sd0, 1'b0);
        send_score(24'sd1, 1'b0);
        send_score(-24'sd1, 1'b0);
        send_score(24'sd8388607, 1'b0);
        send_score(24'sd2, 1'b0);
        send_score(24'sd2, 1'b0);
        send_score(24'sd5, 1'b1);
    endtask

    // a final request alone, positive and negative, and a frame with
    // fewer positives than ranks
    task automatic test_short_frames();
        send_score(24'sd1000, 1'b1);
        send_score(-24'sd70, 1'b1);
        send_score(24'sd0, 1'b1);
        send_score(24'sd300, 1'b0);
        send_score(-24'sd4, 1'b0);
        send_score(24'sd300, 1'b1);
    endtask

    // a class past the label count cuts the report at its rank
    task automatic test_label_cutoff();
        write_label_count(IDX_W'(3));
        send_score(24'sd300, 1'b0);
        send_score(24'sd100, 1'b0);
        send_score(24'sd0, 1'b0);
        send_score(24'sd200, 1'b0);
        send_score(24'sd50, 1'b1);
        write_label_count(IDX_W'(0));
        send_score(24'sd9, 1'b0);
        send_score(24'sd8, 1'b1);
    endtask

    // random frames over several label counts and idling patterns
    task automatic test_random_frames();
        logic [IDX_W-1:0] labels[PHASE_COUNT];
        t_stall_mode      modes [PHASE_COUNT];
        int               gaps  [PHASE_COUNT];
        int               sent;
        int               len;
        labels = '{IDX_W'(1000), IDX_W'(4), IDX_W'(0), IDX_W'(1), IDX_W'(999),
                   IDX_W'($urandom_range(0, 1000))};
        modes  = '{STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_LONG,
                   STALL_RANDOM, STALL_LONG};
        gaps   = '{0, 6, 3, 12, 0, 20};
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_label_count(labels[p]);
            stall_mode    = modes[p];
            burst_gap_max = gaps[p];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = pick_frame_length();
                send_frame(len);
                sent += len;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // result side: stall on a pattern independent of the request side
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        case (stall_mode)
            STALL_NONE: begin
                i_res_ready <= 1'b1;
            end
            STALL_RANDOM: begin
                i_res_ready <= ($urandom_range(0, 99) < 60);
            end
            STALL_PATTERN: begin
                stall_phase = (stall_phase + 1) % 7;
                i_res_ready <= (stall_phase < 4);
            end
            default: begin
                // mostly ready, with occasional long stalls
                if (stall_left > 0) begin
                    stall_left--;
                    i_res_ready <= 1'b0;
                end else begin
                    i_res_ready <= 1'b1;
                    if ($urandom_range(0, 19) == 0)
                        stall_left = $urandom_range(5, 30);
                end
            end
        endcase
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // every accepted result against the oldest ranked expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_ranks.size() == 0) begin
                $display("%0t: unexpected result expected none actual rank %0d index %0d",
                         $time, o_res.rank, o_res.class_index);
                mismatch_count++;
            end else begin
                want = expected_ranks.pop_front();
                check_field("rank", want.rank, o_res.rank);
                check_field("class_index", want.class_index, o_res.class_index);
                check_field("percent", want.percent, o_res.percent);
                check_field("entry_valid", want.entry_valid, o_res.entry_valid);
                check_field("last_of_run", want.last_of_run, o_res.last_of_run);
            end
        end
    end

    // watchdog: too long without any request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_res_valid && i_res_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("top_k_score_select regression: fail");
            $finish;
        end
    end

    initial begin
        clear_ranking();
        // synchronous reset, asserted from the start and released once
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_score_extremes();
        test_short_frames();
        test_label_cutoff();
        test_random_frames();

        drain_results();
        if (mismatch_count == 0 && expected_ranks.size() == 0)
            $display("top_k_score_select regression: pass");
        else
            $display("top_k_score_select regression: fail");
        $finish;
    end

endmodule
